FILE: sv/bpt_pkg.sv
// Shared types and constants for the bidirectional permutation table.
package bpt_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int DATA_W      = ADDR_W;

    typedef enum logic [3:0] {
        MODE_FWD     = 4'd0,
        MODE_INV     = 4'd1,
        MODE_SWAP    = 4'd2,
        MODE_ROTATE  = 4'd3,
        MODE_INVERT  = 4'd4,
        MODE_SQUARE  = 4'd5,
        MODE_REMOVE  = 4'd6,
        MODE_RESET   = 4'd7,
        MODE_EXTEND  = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOOK,
        S_LOOK_W,
        S_SW_RA,
        S_SW_RB,
        S_SW_W1,
        S_SW_W2,
        S_RT_RD,
        S_RT_WR,
        S_SQ_R1,
        S_SQ_R2,
        S_SQ_WR,
        S_CP_RD,
        S_CP_WR,
        S_RM_G,
        S_RM_GW,
        S_RM_RD,
        S_RM_WR,
        S_FILL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

FILE: sv/bpt_ram.sv
// Table memory with one write port and one registered read port.
module bpt_ram
    import bpt_pkg::*;
(
    input  logic              clk,
    input  ram_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [MAX_ENTRIES];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/bpt_ctrl.sv
// Operation sequencer: walks the tables with at most one access per memory at a time.
module bpt_ctrl
    import bpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         mode,
    input  logic [8:0]         first_index,
    input  logic [7:0]         second_index,
    input  logic [8:0]         third_index,
    input  logic [8:0]         end_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         value,
    output logic [8:0]         current_size,
    output logic [1:0]         status,
    output logic               bank,
    output ram_req_t           fwd_req,
    output ram_req_t           inv_req,
    output ram_req_t           scr_req,
    input  logic [DATA_W-1:0]  fwd_rdata,
    input  logic [DATA_W-1:0]  scr_rdata,
    input  logic [DATA_W-1:0]  inv_rdata
);

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [COUNT_W-1:0]  a_reg, a_next;
    logic [ADDR_W-1:0]   b_reg, b_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                bank_reg, bank_next;
    logic [COUNT_W-1:0]  idx_reg, idx_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic [COUNT_W-1:0]  k_reg, k_next;
    logic [COUNT_W-1:0]  base_reg, base_next;
    logic [COUNT_W-1:0]  lim_reg, lim_next;
    logic [DATA_W-1:0]   tmp_reg, tmp_next;
    logic [DATA_W-1:0]   res_value_reg, res_value_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          value_reg, value_next;
    logic [8:0]          size_reg, size_next;
    logic [1:0]          status_reg, status_next;

    logic [COUNT_W-1:0]  idx_inc;
    logic [COUNT_W-1:0]  k_inc;
    logic [COUNT_W-1:0]  pos;
    logic [COUNT_W:0]    ext_sum;
    logic [COUNT_W-1:0]  rot_len;
    logic [COUNT_W-1:0]  rot_off;
    logic [DATA_W-1:0]   adj;

    assign idx_inc = idx_reg + 1'b1;
    assign k_inc   = k_reg + 1'b1;
    assign pos     = base_reg + idx_reg;
    assign ext_sum = {1'b0, count_reg} + {1'b0, first_index};
    assign rot_len = end_index - {1'b0, second_index};
    assign rot_off = third_index - {1'b0, second_index};
    assign adj     = (fwd_rdata > tmp_reg) ? fwd_rdata - 1'b1 : fwd_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        base_reg       <= base_next;
        lim_reg        <= lim_next;
        tmp_reg        <= tmp_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        value_reg      <= value_next;
        size_reg       <= size_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        count_next      = count_reg;
        bank_next       = bank_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        base_next       = base_reg;
        lim_next        = lim_reg;
        tmp_next        = tmp_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        value_next      = value_reg;
        size_next       = size_reg;
        status_next     = status_reg;
        fwd_req         = '0;
        inv_req         = '0;
        scr_req         = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode_t'(mode);
                    a_next          = first_index;
                    b_next          = second_index;
                    idx_next        = '0;
                    n_next          = '0;
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    unique case (mode_t'(mode))
                        MODE_FWD, MODE_INV:
                        begin
                            if (first_index < count_reg)
                                state_next = S_LOOK;
                            else
                                res_status_next = ST_RANGE;
                        end
                        MODE_SWAP:
                        begin
                            if (first_index < count_reg && {1'b0, second_index} < count_reg)
                                state_next = S_SW_RA;
                            else
                                res_status_next = ST_RANGE;
                        end
                        MODE_ROTATE:
                        begin
                            if ({1'b0, second_index} <= third_index
                                && third_index <= end_index && end_index <= count_reg)
                            begin
                                base_next  = {1'b0, second_index};
                                lim_next   = rot_len;
                                k_next     = (rot_off == rot_len) ? '0 : rot_off;
                                state_next = S_RT_RD;
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                            end
                        end
                        MODE_INVERT:
                        begin
                            bank_next = !bank_reg;
                        end
                        MODE_SQUARE:
                        begin
                            base_next  = '0;
                            lim_next   = count_reg;
                            state_next = S_SQ_R1;
                        end
                        MODE_REMOVE:
                        begin
                            if (first_index < count_reg)
                                state_next = S_RM_G;
                            else
                                res_status_next = ST_RANGE;
                        end
                        MODE_RESET:
                        begin
                            if ({1'b0, first_index} > (COUNT_W+1)'(MAX_ENTRIES))
                            begin
                                res_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                lim_next   = first_index;
                                state_next = S_FILL;
                            end
                        end
                        MODE_EXTEND:
                        begin
                            if (ext_sum > (COUNT_W+1)'(MAX_ENTRIES))
                            begin
                                res_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                lim_next   = ext_sum[COUNT_W-1:0];
                                state_next = S_FILL;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                fwd_req.raddr = a_reg[ADDR_W-1:0];
                inv_req.raddr = a_reg[ADDR_W-1:0];
                state_next    = S_LOOK_W;
            end
            S_LOOK_W:
            begin
                res_value_next = (mode_reg == MODE_FWD) ? fwd_rdata : inv_rdata;
                state_next     = S_DONE;
            end
            S_SW_RA:
            begin
                fwd_req.raddr = a_reg[ADDR_W-1:0];
                state_next    = S_SW_RB;
            end
            S_SW_RB:
            begin
                fwd_req.raddr = b_reg;
                tmp_next      = fwd_rdata;
                state_next    = S_SW_W1;
            end
            S_SW_W1:
            begin
                fwd_req.we    = 1'b1;
                fwd_req.waddr = a_reg[ADDR_W-1:0];
                fwd_req.wdata = fwd_rdata;
                inv_req.we    = 1'b1;
                inv_req.waddr = fwd_rdata;
                inv_req.wdata = a_reg[ADDR_W-1:0];
                state_next    = S_SW_W2;
            end
            S_SW_W2:
            begin
                fwd_req.we    = 1'b1;
                fwd_req.waddr = b_reg;
                fwd_req.wdata = tmp_reg;
                inv_req.we    = 1'b1;
                inv_req.waddr = tmp_reg;
                inv_req.wdata = b_reg;
                state_next    = S_DONE;
            end
            S_RT_RD:
            begin
                if (idx_reg == lim_reg)
                begin
                    idx_next   = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    fwd_req.raddr = ADDR_W'(base_reg + k_reg);
                    state_next    = S_RT_WR;
                end
            end
            S_RT_WR:
            begin
                scr_req.we    = 1'b1;
                scr_req.waddr = idx_reg[ADDR_W-1:0];
                scr_req.wdata = fwd_rdata;
                idx_next      = idx_inc;
                k_next        = (k_inc == lim_reg) ? '0 : k_inc;
                state_next    = S_RT_RD;
            end
            S_SQ_R1:
            begin
                if (idx_reg == lim_reg)
                begin
                    idx_next   = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    fwd_req.raddr = idx_reg[ADDR_W-1:0];
                    state_next    = S_SQ_R2;
                end
            end
            S_SQ_R2:
            begin
                fwd_req.raddr = fwd_rdata;
                state_next    = S_SQ_WR;
            end
            S_SQ_WR:
            begin
                scr_req.we    = 1'b1;
                scr_req.waddr = idx_reg[ADDR_W-1:0];
                scr_req.wdata = fwd_rdata;
                idx_next      = idx_inc;
                state_next    = S_SQ_R1;
            end
            S_CP_RD:
            begin
                if (idx_reg == lim_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scr_req.raddr = idx_reg[ADDR_W-1:0];
                    state_next    = S_CP_WR;
                end
            end
            S_CP_WR:
            begin
                fwd_req.we    = 1'b1;
                fwd_req.waddr = pos[ADDR_W-1:0];
                fwd_req.wdata = scr_rdata;
                inv_req.we    = 1'b1;
                inv_req.waddr = scr_rdata;
                inv_req.wdata = pos[ADDR_W-1:0];
                idx_next      = idx_inc;
                state_next    = S_CP_RD;
            end
            S_RM_G:
            begin
                fwd_req.raddr = a_reg[ADDR_W-1:0];
                state_next    = S_RM_GW;
            end
            S_RM_GW:
            begin
                tmp_next   = fwd_rdata;
                state_next = S_RM_RD;
            end
            S_RM_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else if (idx_reg == a_reg)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    fwd_req.raddr = idx_reg[ADDR_W-1:0];
                    state_next    = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                // Positions below the read pointer are rewritten compacted.
                fwd_req.we    = 1'b1;
                fwd_req.waddr = n_reg[ADDR_W-1:0];
                fwd_req.wdata = adj;
                inv_req.we    = 1'b1;
                inv_req.waddr = adj;
                inv_req.wdata = n_reg[ADDR_W-1:0];
                n_next        = n_reg + 1'b1;
                idx_next      = idx_inc;
                state_next    = S_RM_RD;
            end
            S_FILL:
            begin
                if (idx_reg == lim_reg)
                begin
                    count_next = lim_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    fwd_req.we    = 1'b1;
                    fwd_req.waddr = idx_reg[ADDR_W-1:0];
                    fwd_req.wdata = idx_reg[ADDR_W-1:0];
                    inv_req.we    = 1'b1;
                    inv_req.waddr = idx_reg[ADDR_W-1:0];
                    inv_req.wdata = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_inc;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_value_reg;
                    size_next      = count_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign current_size = size_reg;
    assign status       = status_reg;
    assign bank         = bank_reg;

endmodule

FILE: sv/bidirectional_permutation_table_unit.sv
// Top level of the bidirectional permutation table: sequencer and table memories.
//
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  mode, first_index, second_index,
//                                          third_index, end_index
// result   out        out_valid/out_stall  value, current_size, status
//
// One item is worked at a time by a sequencer that makes one access per
// memory per cycle. Rotate and square gather forward entries into the
// scratch table and copy them back; remove compacts the tables in place;
// the single read port of the forward table sets their pace.
// Reset clears the entry count, bank select, output valid and state only; table contents start undefined.
// A finished result sits in the output register while the next item is
// taken; a stalled output holds the sequencer only in its final state.
module bidirectional_permutation_table_unit
    import bpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] mode,
    input  logic [8:0] first_index,
    input  logic [7:0] second_index,
    input  logic [8:0] third_index,
    input  logic [8:0] end_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] value,
    output logic [8:0] current_size,
    output logic [1:0] status
);

    // Invert is done by exchanging the roles of the two physical tables.
    logic              bank;
    ram_req_t          fwd_req, inv_req, scr_req;
    ram_req_t          ram0_req, ram1_req;
    logic [DATA_W-1:0] ram0_rdata, ram1_rdata, scr_rdata;
    logic [DATA_W-1:0] fwd_rdata, inv_rdata;

    assign ram0_req  = bank ? inv_req : fwd_req;
    assign ram1_req  = bank ? fwd_req : inv_req;
    assign fwd_rdata = bank ? ram1_rdata : ram0_rdata;
    assign inv_rdata = bank ? ram0_rdata : ram1_rdata;

    bpt_ram u_ram0
    (
        .clk   (clk),
        .req   (ram0_req),
        .rdata (ram0_rdata)
    );

    bpt_ram u_ram1
    (
        .clk   (clk),
        .req   (ram1_req),
        .rdata (ram1_rdata)
    );

    // Scratch table holds the rearranged forward entries between passes.
    bpt_ram u_scratch
    (
        .clk   (clk),
        .req   (scr_req),
        .rdata (scr_rdata)
    );

    bpt_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .first_index  (first_index),
        .second_index (second_index),
        .third_index  (third_index),
        .end_index    (end_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .current_size (current_size),
        .status       (status),
        .bank         (bank),
        .fwd_req      (fwd_req),
        .inv_req      (inv_req),
        .scr_req      (scr_req),
        .fwd_rdata    (fwd_rdata),
        .scr_rdata    (scr_rdata),
        .inv_rdata    (inv_rdata)
    );

endmodule
